// ----- sv/mect_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mect_pkg: shared types and constants for the MRU effect cache tag list
// Sizes of the ordered list, field widths, result codes, register indexes,
// controller states and the command/status bundles between ctrl and datapath.
// ----------------------------------------------------------------------------
package mect_pkg;

	// list geometry
	localparam int CACHE_LIMIT = 12;
	localparam int LIST_DEPTH  = CACHE_LIMIT + 1;
	localparam int RANK_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W       = $clog2(LIST_DEPTH + 1);

	// field widths
	localparam int ID_W     = 15;
	localparam int REQ_W    = 16;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 15;
	localparam int CFG_IDX_W = 1;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_COUNT = 1'd1;

	// result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_REJECT = 2'd0,
		ST_HIT    = 2'd1,
		ST_MISS   = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_COMMIT,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request beat
		logic step;      // advance search index
		logic mark_hit;  // current index matches
		logic commit;    // update list and write hit/miss result
		logic reject;    // write rejected result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_ok;    // request passed the range check
		logic empty;     // list holds no entries
		logic match;     // entry at search index equals request
		logic at_last;   // search index is the last valid entry
	} sts_t;

endpackage
`default_nettype wire

// ----- sv/mect_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mect_ctrl: request sequencer
// Walks one request through range check, linear search from the head,
// list update and result hand-off.
// ----------------------------------------------------------------------------
module mect_ctrl
	import mect_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire  out_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!sts.req_ok)    state_d = S_OUT;
				else if (sts.empty) state_d = S_COMMIT;
				else                state_d = S_SEARCH;
			end
			S_SEARCH: begin
				if (sts.match || sts.at_last) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_CHECK: begin
				cmd.reject = !sts.req_ok;
			end
			S_SEARCH: begin
				cmd.mark_hit = sts.match;
				cmd.step     = !sts.match && !sts.at_last;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
			end
			S_OUT: begin
				out_valid = 1'b1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/mect_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mect_dp: tag list datapath
// Holds config, the ordered id list and its length, the search index, and
// the result registers. Move-to-front is a single conditional shift on commit.
// ----------------------------------------------------------------------------
module mect_dp
	import mect_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_W-1:0]      cfg_wdata,
	input  wire signed [REQ_W-1:0] effect_id,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [STATUS_W-1:0]  status,
	output logic [RANK_W-1:0]    hit_rank,
	output logic                 evicted_valid,
	output logic [ID_W-1:0]      evicted_id,
	output logic [CNT_W-1:0]     entry_count
);

	logic              enable_q;
	logic [ID_W-1:0]   count_q;
	logic [ID_W-1:0]   id_q;
	logic              ok_q;
	logic              hit_q;
	logic [RANK_W-1:0] idx_q;
	logic [CNT_W-1:0]  len_q;
	logic [ID_W-1:0]   list_q [LIST_DEPTH];

	logic [STATUS_W-1:0] status_q;
	logic [RANK_W-1:0]   rank_q;
	logic                ev_valid_q;
	logic [ID_W-1:0]     ev_id_q;
	logic [CNT_W-1:0]    cnt_q;

	logic              full;
	logic              evict;
	logic [RANK_W-1:0] pos;
	logic [CNT_W-1:0]  len_next;
	logic              req_ok;

	// range check on the incoming beat
	assign req_ok = enable_q && !effect_id[REQ_W-1] && (effect_id[ID_W-1:0] < count_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			count_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CACHE_ENABLE: enable_q <= cfg_wdata[0];
				REG_EFFECT_COUNT: count_q  <= cfg_wdata[ID_W-1:0];
				default: ;
			endcase
		end
	end

	// request capture and search index
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q  <= effect_id[ID_W-1:0];
			ok_q  <= req_ok;
			hit_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cmd.step)     idx_q <= idx_q + RANK_W'(1);
			if (cmd.mark_hit) hit_q <= 1'b1;
		end
	end

	// status back to the controller
	always_comb begin
		sts.req_ok  = ok_q;
		sts.empty   = (len_q == '0);
		sts.match   = (list_q[idx_q] == id_q);
		sts.at_last = (CNT_W'(idx_q) == len_q - CNT_W'(1));
	end

	// update plan: shift depth and new length
	assign full  = (len_q == CNT_W'(LIST_DEPTH));
	assign evict = !hit_q && full;
	always_comb begin
		if (hit_q) begin
			pos      = idx_q;
			len_next = len_q;
		end else if (full) begin
			pos      = RANK_W'(LIST_DEPTH - 1);
			len_next = len_q;
		end else begin
			pos      = len_q[RANK_W-1:0];
			len_next = len_q + CNT_W'(1);
		end
	end

	// list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.commit) begin
			len_q <= len_next;
		end
	end

	// move-to-front shift: entries at or above 1 and up to pos slide down
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			list_q[0] <= id_q;
			for (int j = 1; j < LIST_DEPTH; j++) begin
				if (RANK_W'(j) <= pos) list_q[j] <= list_q[j-1];
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.reject) begin
			status_q   <= ST_REJECT;
			rank_q     <= '0;
			ev_valid_q <= 1'b0;
			ev_id_q    <= '0;
			cnt_q      <= len_q;
		end else if (cmd.commit) begin
			status_q   <= hit_q ? ST_HIT : ST_MISS;
			rank_q     <= hit_q ? idx_q : '0;
			ev_valid_q <= evict;
			ev_id_q    <= evict ? list_q[LIST_DEPTH-1] : '0;
			cnt_q      <= len_next;
		end
	end

	assign status        = status_q;
	assign hit_rank      = rank_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_id    = ev_id_q;
	assign entry_count   = cnt_q;

endmodule
`default_nettype wire

// ----- sv/mru_effect_cache_tags_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mru_effect_cache_tags_top: most-recently-used tag list for effect ids
// Checks each requested id against enable and effect count, searches the
// list from the head, moves a hit to the front or inserts a miss at the
// front (evicting the tail when full), and reports one result beat.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | effect_id
//  out     | out_valid / out_stall | status, hit_rank, evicted_valid,
//          |                       | evicted_id, entry_count
//  cfg     | cfg_we                | cfg_index, cfg_wdata
//
//  One request at a time, one compare per cycle. After accept, a rejected
//  request goes straight to its result beat; a miss or hit is searched from
//  the head and committed first. The block returns to idle once the beat is taken.
//  Reset clears config to enable=1, count=0 and empties the list.
//  in_stall stays high from accept until the result beat is taken.
// ----------------------------------------------------------------------------
module mru_effect_cache_tags_top
	import mect_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_W-1:0]        cfg_wdata,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire signed [REQ_W-1:0] effect_id,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic [STATUS_W-1:0]    status,
	output logic [RANK_W-1:0]      hit_rank,
	output logic                   evicted_valid,
	output logic [ID_W-1:0]        evicted_id,
	output logic [CNT_W-1:0]       entry_count
);

	cmd_t cmd;
	sts_t sts;

	mect_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	mect_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.effect_id     (effect_id),
		.cmd           (cmd),
		.sts           (sts),
		.status        (status),
		.hit_rank      (hit_rank),
		.evicted_valid (evicted_valid),
		.evicted_id    (evicted_id),
		.entry_count   (entry_count)
	);

`ifndef NO_ASSERTIONS
	// never take a new beat while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("input accepted while result pending");

	// rejected beats carry no rank or eviction
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_REJECT) |-> (hit_rank == '0 && !evicted_valid))
		else $error("rejected result carries hit or eviction");

	// eviction only on a miss into a full list
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && evicted_valid) |->
			(status == ST_MISS && entry_count == CNT_W'(LIST_DEPTH)))
		else $error("eviction without full-list miss");

	// a hit rank lies inside the list
	a_rank_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_HIT) |->
			(CNT_W'(hit_rank) < entry_count))
		else $error("hit rank beyond list length");
`endif

endmodule
`default_nettype wire
